// File: rtl/core/frl_pkg.sv
// shared types and constants for the frame rate limiter
`default_nettype none
package frl_pkg;

  localparam int unsigned SpeedW  = 10;
  localparam int unsigned CountW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned DivW    = 26;  // 65535 * 1000 fits in 26 bits
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [SpeedW-1:0] SpeedMax   = 10'd1023;
  localparam logic [SpeedW-1:0] SpeedReset = 10'd60;
  localparam logic [SpeedW-1:0] SpeedHigh  = 10'd60;
  localparam logic [SpeedW-1:0] SpeedMid   = 10'd15;
  localparam logic [SpeedW-1:0] StepBig    = 10'd10;
  localparam logic [SpeedW-1:0] StepMid    = 10'd5;
  localparam logic [CountW-1:0] CountMax   = 16'hFFFF;
  localparam logic [WaitW-1:0]  WaitMax    = 16'hFFFF;
  localparam logic [TimeW-1:0]  MsPerSec   = 32'd1000;

  typedef enum logic [1:0] {
    FUNC_FRAME   = 2'd0,
    FUNC_UP      = 2'd1,
    FUNC_DOWN    = 2'd2,
    FUNC_RESTORE = 2'd3
  } func_e;

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [SpeedW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/frl_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module frl_div
  import frl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [SpeedW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [SpeedW-1:0]   dvs_q, dvs_d;

  logic [SpeedW:0]     trial;
  logic [SpeedW+1:0]   diff;
  logic                borrow;

  // shift in the next dividend bit and try the subtract
  assign trial  = {rem_q, quo_q[DivW-1]};
  assign diff   = {1'b0, trial} - {2'b00, dvs_q};
  assign borrow = diff[SpeedW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = borrow ? trial[SpeedW-1:0] : diff[SpeedW-1:0];
      quo_d = {quo_q[DivW-2:0], ~borrow};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// File: rtl/core/frame_rate_limiter.sv
// frame rate limiter top level: pacing state, sequencer and output register
//
// Paces frames to a target rate. A frame beat carries the current ms time;
// the block answers with the wait until the frame is due, window_done and
// the frame count when a one-second window closed, and the current target
// speed. Speed up, slow down and restore beats answer in the cycle after
// acceptance. A frame beat passes through the frames*1000 product step,
// the serial divider (one quotient bit per cycle over 26 bits, then a
// completion flag), and the elapsed time and wait arithmetic steps before
// its result is registered. Input ready is low while a beat is at work and
// while a result waits in the output register.
// base_rate is loaded through cfg_we_i/cfg_wdata_i and is only sampled by
// restore beats.
`default_nettype none
module frame_rate_limiter
  import frl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SpeedW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [TimeW-1:0]  now_ms_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WaitW-1:0]       wait_ms_o,
  output logic                   window_done_o,
  output logic [CountW-1:0]      frame_rate_o,
  output logic [SpeedW-1:0]      current_speed_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_ELAP = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [SpeedW-1:0]   base_q, base_d;
  logic [SpeedW-1:0]   speed_q, speed_d;
  logic [CountW-1:0]   fc_q, fc_d;
  logic [TimeW-1:0]    ws_q, ws_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [DivW-1:0]     tgt_q, tgt_d;
  logic [TimeW-1:0]    elap_q, elap_d;
  logic                ovld_q, ovld_d;
  logic [WaitW-1:0]    wait_q, wait_d;
  logic                done_q, done_d;
  logic [CountW-1:0]   rate_q, rate_d;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_acc;
  logic [TimeW-1:0]    tgt_ext;
  logic                early;
  logic [DivW-1:0]     wdiff;
  logic [TimeW-1:0]    el_eff;

  function automatic logic [SpeedW-1:0] step_up(input logic [SpeedW-1:0] s);
    logic [SpeedW:0] n;
    if (s >= SpeedHigh)     n = {1'b0, s} + {1'b0, StepBig};
    else if (s >= SpeedMid) n = {1'b0, s} + {1'b0, StepMid};
    else                    n = {1'b0, s} + 1'b1;
    return (n > {1'b0, SpeedMax}) ? SpeedMax : n[SpeedW-1:0];
  endfunction

  function automatic logic [SpeedW-1:0] step_down(input logic [SpeedW-1:0] s);
    logic [SpeedW-1:0] n;
    if (s > SpeedHigh)     n = s - StepBig;
    else if (s > SpeedMid) n = s - StepMid;
    else if (s > 10'd1)    n = s - 1'b1;
    else                   n = 10'd1;
    return n;
  endfunction

  frl_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE) && !ovld_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // frames * 1000 goes straight into the divider's dividend register
  assign div_req.start    = (state_q == S_MUL);
  assign div_req.dividend = DivW'(fc_q) * DivW'(MsPerSec);
  assign div_req.divisor  = speed_q;

  assign tgt_ext = {{(TimeW-DivW){1'b0}}, tgt_q};
  assign early   = elap_q < tgt_ext;
  assign wdiff   = tgt_q - elap_q[DivW-1:0];
  // an early frame is assumed to wait until exactly the due time
  assign el_eff  = early ? tgt_ext : elap_q;

  always_comb begin
    state_d = state_q;
    base_d  = cfg_we_i ? cfg_wdata_i : base_q;
    speed_d = speed_q;
    fc_d    = fc_q;
    ws_d    = ws_q;
    now_d   = now_q;
    tgt_d   = tgt_q;
    elap_d  = elap_q;
    ovld_d  = ovld_q && !out_ready_i;
    wait_d  = wait_q;
    done_d  = done_q;
    rate_d  = rate_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (func_e'(func_i))
            FUNC_FRAME: begin
              fc_d    = (fc_q == CountMax) ? fc_q : fc_q + 1'b1;
              now_d   = now_ms_i;
              state_d = S_MUL;
            end
            FUNC_UP:      speed_d = step_up(speed_q);
            FUNC_DOWN:    speed_d = step_down(speed_q);
            FUNC_RESTORE: speed_d = (base_q == '0) ? 10'd1 : base_q;
            default:      speed_d = speed_q;
          endcase
          if (func_e'(func_i) != FUNC_FRAME) begin
            fc_d   = '0;
            ovld_d = 1'b1;
            wait_d = '0;
            done_d = 1'b0;
            rate_d = '0;
          end
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          tgt_d   = div_rsp.quotient;
          state_d = S_ELAP;
        end
      end
      S_ELAP: begin
        elap_d  = now_q - ws_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        wait_d = '0;
        if (early) begin
          wait_d = (|wdiff[DivW-1:WaitW]) ? WaitMax : wdiff[WaitW-1:0];
        end
        done_d = 1'b0;
        rate_d = '0;
        if (el_eff >= MsPerSec) begin
          done_d = 1'b1;
          rate_d = fc_q;
          fc_d   = '0;
          ws_d   = early ? ws_q + tgt_ext : now_q;
        end
        ovld_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= SpeedReset;
      speed_q <= SpeedReset;
      fc_q    <= '0;
      ws_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      speed_q <= speed_d;
      fc_q    <= fc_d;
      ws_q    <= ws_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    tgt_q  <= tgt_d;
    elap_q <= elap_d;
    wait_q <= wait_d;
    done_q <= done_d;
    rate_q <= rate_d;
  end

  assign out_valid_o     = ovld_q;
  assign wait_ms_o       = wait_q;
  assign window_done_o   = done_q;
  assign frame_rate_o    = rate_q;
  assign current_speed_o = speed_q;

`ifndef SYNTHESIS
  a_speed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q != '0)
    else $error("target speed dropped to zero");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o || state_q == S_MUL)
    else $error("accepted beat produced neither result nor work");
`endif

endmodule
`default_nettype wire

// File: verif/frl_checker.sv
// scoreboard for the frame rate limiter: watches both channels, predicts and compares
module frl_checker
  import frl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SpeedW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        func_i,
  input  logic [TimeW-1:0]  now_ms_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [WaitW-1:0]  wait_ms_i,
  input  logic              window_done_i,
  input  logic [CountW-1:0] frame_rate_i,
  input  logic [SpeedW-1:0] current_speed_i,
  output int                n_open_o,
  output int                n_fail_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DueW = TimeW + SpeedW;

  typedef struct packed {
    logic [WaitW-1:0]  wait_ms;
    logic              window_done;
    logic [CountW-1:0] frame_rate;
    logic [SpeedW-1:0] speed;
  } pace_res_t;

  logic [SpeedW-1:0] pr_base;
  logic [SpeedW-1:0] pr_speed;
  logic [CountW-1:0] pr_count;
  logic [TimeW-1:0]  pr_start;
  pace_res_t         pace_q[$];
  int                n_fail = 0;
  int                n_results = 0;

  assign n_fail_o = n_fail;

  task automatic report_fail(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_fail($sformatf("result %0d %s: got %0d, want %0d", n_results, name, got, want));
    end
  endtask

  // advances the pacing state by one input beat and returns the result it causes
  function automatic pace_res_t pace_item(input logic [1:0] f, input logic [TimeW-1:0] t);
    pace_res_t         r;
    logic [SpeedW-1:0] div;
    logic [DueW-1:0]   due;
    logic [TimeW-1:0]  elapsed;
    logic [TimeW-1:0]  t_eff;
    logic [SpeedW:0]   nxt;
    r     = '0;
    t_eff = t;
    case (func_e'(f))
      FUNC_FRAME: begin
        div = (pr_speed == '0) ? SpeedW'(1) : pr_speed;
        if (pr_count != CountMax) pr_count = pr_count + 1'b1;
        due     = (DueW'(pr_count) * DueW'(MsPerSec)) / DueW'(div);
        elapsed = t - pr_start;
        // early frame: the wait is assumed to end exactly on the due time
        if (DueW'(elapsed) < due) begin
          r.wait_ms = (due - DueW'(elapsed) > DueW'(WaitMax)) ? WaitMax :
                      WaitW'(due - DueW'(elapsed));
          elapsed   = due[TimeW-1:0];
          t_eff     = pr_start + due[TimeW-1:0];
        end
        if (elapsed >= MsPerSec) begin
          r.window_done = 1'b1;
          r.frame_rate  = pr_count;
          pr_count      = '0;
          pr_start      = t_eff;
        end
      end
      FUNC_UP: begin
        if (pr_speed >= SpeedHigh) nxt = (SpeedW+1)'(pr_speed) + (SpeedW+1)'(StepBig);
        else if (pr_speed >= SpeedMid) nxt = (SpeedW+1)'(pr_speed) + (SpeedW+1)'(StepMid);
        else nxt = (SpeedW+1)'(pr_speed) + 1'b1;
        pr_speed = (nxt > (SpeedW+1)'(SpeedMax)) ? SpeedMax : nxt[SpeedW-1:0];
        pr_count = '0;
      end
      FUNC_DOWN: begin
        if (pr_speed > SpeedHigh) pr_speed = pr_speed - StepBig;
        else if (pr_speed > SpeedMid) pr_speed = pr_speed - StepMid;
        else if (pr_speed > SpeedW'(1)) pr_speed = pr_speed - 1'b1;
        pr_count = '0;
      end
      FUNC_RESTORE: begin
        pr_speed = (pr_base == '0) ? SpeedW'(1) : pr_base;
        pr_count = '0;
      end
      default: ;
    endcase
    r.speed = pr_speed;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    pace_res_t want;
    if (!rst_ni) begin
      pr_base  = SpeedReset;
      pr_speed = SpeedReset;
      pr_count = '0;
      pr_start = '0;
      pace_q.delete();
      n_open_o <= 0;
    end else begin
      if (cfg_we_i) pr_base = cfg_wdata_i;
      if (in_valid_i && in_ready_i) pace_q.push_back(pace_item(func_i, now_ms_i));
      if (out_valid_i && out_ready_i) begin
        if (pace_q.size() == 0) begin
          report_fail($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = pace_q.pop_front();
          check_field("wait_ms", 32'(wait_ms_i), 32'(want.wait_ms));
          check_field("window_done", 32'(window_done_i), 32'(want.window_done));
          check_field("frame_rate", 32'(frame_rate_i), 32'(want.frame_rate));
          check_field("current_speed", 32'(current_speed_i), 32'(want.speed));
        end
        n_results++;
      end
      n_open_o <= pace_q.size();
    end
  end

endmodule

// File: verif/frame_rate_limiter_tb.sv
// testbench top for the frame rate limiter: clock, reset, stimulus and verdict
module frame_rate_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frl_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SpeedW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        func_i;
  logic [TimeW-1:0]  now_ms_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [WaitW-1:0]  wait_ms_o;
  logic              window_done_o;
  logic [CountW-1:0] frame_rate_o;
  logic [SpeedW-1:0] current_speed_o;

  int               n_open;
  int               n_fail;
  int               send_idle_pct;
  int               recv_stall_pct;
  logic [TimeW-1:0] wall_ms;

  always #10ns clk_i = ~clk_i;

  frame_rate_limiter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wait_ms_o      (wait_ms_o),
    .window_done_o  (window_done_o),
    .frame_rate_o   (frame_rate_o),
    .current_speed_o(current_speed_o)
  );

  frl_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .func_i         (func_i),
    .now_ms_i       (now_ms_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wait_ms_i      (wait_ms_o),
    .window_done_i  (window_done_o),
    .frame_rate_i   (frame_rate_o),
    .current_speed_i(current_speed_o),
    .n_open_o       (n_open),
    .n_fail_o       (n_fail)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // valid stays high across back-to-back beats, dropped only for a gap
  task automatic send_beat(input func_e f, input logic [TimeW-1:0] t);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 45);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    now_ms_i   <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (n_open != 0);
  endtask

  task automatic set_base_rate(input logic [SpeedW-1:0] rate);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly steady frame pacing, with late frames, time going backwards and jumps
  function automatic logic [TimeW-1:0] next_frame_time();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) wall_ms = wall_ms + $urandom_range(0, 20);
    else if (roll < 85) wall_ms = wall_ms + $urandom_range(20, 300);
    else if (roll < 93) wall_ms = wall_ms + $urandom_range(900, 2500);
    else if (roll < 97) wall_ms = wall_ms - $urandom_range(1, 5000);
    else wall_ms = $urandom();
    return wall_ms;
  endfunction

  task automatic run_directed();
    send_beat(FUNC_FRAME, 32'h0000_0000);
    send_beat(FUNC_FRAME, 32'h0000_0000);
    send_beat(FUNC_FRAME, 32'hFFFF_FFFF);  // backwards in wrapped time, window closes
    send_beat(FUNC_FRAME, 32'h0000_0010);  // time wraps past zero
    send_beat(FUNC_FRAME, 32'h0000_0400);
    send_beat(FUNC_UP, $urandom());
    send_beat(FUNC_DOWN, $urandom());
    send_beat(FUNC_DOWN, $urandom());
    send_beat(FUNC_RESTORE, $urandom());
    // zero base rate restores to the minimum speed
    set_base_rate('0);
    send_beat(FUNC_RESTORE, $urandom());
    send_beat(FUNC_DOWN, $urandom());
    send_beat(FUNC_FRAME, 32'h8000_0000);
    send_beat(FUNC_FRAME, 32'h8000_0000);
    send_beat(FUNC_UP, $urandom());
    set_base_rate(SpeedMax);
    send_beat(FUNC_RESTORE, $urandom());
    send_beat(FUNC_UP, $urandom());
    send_beat(FUNC_FRAME, 32'h8000_1000);
    send_beat(FUNC_DOWN, $urandom());
    // step size boundaries around 15 and 60
    set_base_rate(SpeedMid);
    send_beat(FUNC_RESTORE, $urandom());
    send_beat(FUNC_UP, $urandom());
    send_beat(FUNC_DOWN, $urandom());
    send_beat(FUNC_DOWN, $urandom());
    send_beat(FUNC_UP, $urandom());
    set_base_rate(SpeedHigh + 1'b1);
    send_beat(FUNC_RESTORE, $urandom());
    send_beat(FUNC_DOWN, $urandom());
  endtask

  initial begin
    int    sent;
    int    roll;
    int    burst;
    func_e f;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_FRAME;
    now_ms_i       = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wall_ms        = 32'h8000_2000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_base_rate(SpeedMax);
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 0;
          set_base_rate('0);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 54;
          wall_ms        = 32'hFFFF_F000;
          set_base_rate(SpeedW'(1));
        end
        default: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
          set_base_rate(SpeedW'($urandom_range(1, 1023)));
        end
      endcase
      sent = 0;
      while (sent < 375) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          // long runs of speed steps reach both speed limits
          burst = $urandom_range(5, 120);
          f     = (roll == 0) ? FUNC_UP : FUNC_DOWN;
          repeat (burst) send_beat(f, $urandom());
          sent += burst;
        end else begin
          if (roll < 87) send_beat(FUNC_FRAME, next_frame_time());
          else if (roll < 92) send_beat(FUNC_UP, $urandom());
          else if (roll < 97) send_beat(FUNC_DOWN, $urandom());
          else send_beat(FUNC_RESTORE, $urandom());
          sent++;
        end
      end
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: frame_rate_limiter.f
rtl/core/frl_pkg.sv
rtl/core/frl_div.sv
rtl/core/frame_rate_limiter.sv
verif/frl_checker.sv
verif/frame_rate_limiter_tb.sv
